/* sv/temperature_banded_pump_cycler_core_defines.svh */
// Assertion helpers used by the pump cycler core
`ifndef TEMPERATURE_BANDED_PUMP_CYCLER_CORE_DEFINES_SVH
`define TEMPERATURE_BANDED_PUMP_CYCLER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define TBPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define TBPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tbpc_pkg.sv */
`timescale 1ns / 1ps

package tbpc_pkg;

  // Field and counter widths
  localparam int TEMP_W  = 12;
  localparam int TIME_W  = 16;
  localparam int DATA_W  = 32;
  localparam int TOTAL_W = 32;
  localparam int IDX_W   = 3;
  localparam int CNT_W   = 26;
  localparam int LIM_W   = CNT_W + 1;
  localparam int NUM_SETS = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Reset values of the configuration
  localparam logic signed [TEMP_W-1:0] LOW_THR_RST  = 12'sd320;
  localparam logic signed [TEMP_W-1:0] HIGH_THR_RST = 12'sd400;
  localparam int TIME_RST_S = 900;

  // Band codes as reported on the result channel
  typedef enum logic [2:0] {
    BAND_CONT  = 3'd0,
    BAND_LOW   = 3'd1,
    BAND_MID   = 3'd2,
    BAND_HIGH  = 3'd3,
    BAND_NIGHT = 3'd4
  } band_t;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_CONTINUOUS  = 3'd0,
    REG_LOW_THR     = 3'd1,
    REG_HIGH_THR    = 3'd2,
    REG_LOW_TIMES   = 3'd3,
    REG_MID_TIMES   = 3'd4,
    REG_HIGH_TIMES  = 3'd5,
    REG_NIGHT_TIMES = 3'd6
  } cfg_idx_t;

  // Time set slots inside the limit tables
  localparam logic [1:0] SET_LOW   = 2'd0;
  localparam logic [1:0] SET_MID   = 2'd1;
  localparam logic [1:0] SET_HIGH  = 2'd2;
  localparam logic [1:0] SET_NIGHT = 2'd3;

  // Live configuration; times are kept as tick limits
  typedef struct packed {
    logic                              continuous;
    logic signed [TEMP_W-1:0]          low_thr;
    logic signed [TEMP_W-1:0]          high_thr;
    logic [NUM_SETS-1:0][LIM_W-1:0]    lim_on;
    logic [NUM_SETS-1:0][LIM_W-1:0]    lim_off;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic               pump_on;
    band_t              band;
    logic [TOTAL_W-1:0] total;
  } res_t;

  // A limit the saturated counter can never reach is stored as 2^CNT_W
  function automatic logic [LIM_W-1:0] clamp_limit(input logic [2*TIME_W-1:0] product);
    logic [LIM_W-1:0] lim;
    if (product > {{(2*TIME_W-CNT_W){1'b0}}, CNT_MAX}) begin
      lim = {1'b1, {CNT_W{1'b0}}};
    end else begin
      lim = product[LIM_W-1:0];
    end
    return lim;
  endfunction

endpackage

/* sv/tbpc_cfg_regs.sv */
`timescale 1ns / 1ps

module tbpc_cfg_regs #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [tbpc_pkg::IDX_W-1:0]    wr_idx,
  input  logic [tbpc_pkg::DATA_W-1:0]   wr_data,
  output tbpc_pkg::cfg_t                cfg
);

  localparam int TW = tbpc_pkg::TIME_W;
  localparam logic [2*TW-1:0] TPS_L = (2*TW)'(TICKS_PER_SECOND);
  localparam logic [tbpc_pkg::LIM_W-1:0] LIM_RST =
    tbpc_pkg::clamp_limit((2*TW)'(tbpc_pkg::TIME_RST_S * TICKS_PER_SECOND));

  tbpc_pkg::cfg_t cfg_r;
  tbpc_pkg::cfg_t cfg_nxt;
  logic [2*TW-1:0] prod_on;
  logic [2*TW-1:0] prod_off;
  logic [tbpc_pkg::LIM_W-1:0] lim_on_new;
  logic [tbpc_pkg::LIM_W-1:0] lim_off_new;

  // seconds to ticks, done once at write time
  assign prod_on     = (2*TW)'(wr_data[TW-1:0]) * TPS_L;
  assign prod_off    = (2*TW)'(wr_data[2*TW-1:TW]) * TPS_L;
  assign lim_on_new  = tbpc_pkg::clamp_limit(prod_on);
  assign lim_off_new = tbpc_pkg::clamp_limit(prod_off);

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (tbpc_pkg::cfg_idx_t'(wr_idx))
        tbpc_pkg::REG_CONTINUOUS: cfg_nxt.continuous = wr_data[0];
        tbpc_pkg::REG_LOW_THR:    cfg_nxt.low_thr    = wr_data[tbpc_pkg::TEMP_W-1:0];
        tbpc_pkg::REG_HIGH_THR:   cfg_nxt.high_thr   = wr_data[tbpc_pkg::TEMP_W-1:0];
        tbpc_pkg::REG_LOW_TIMES: begin
          cfg_nxt.lim_on[tbpc_pkg::SET_LOW]  = lim_on_new;
          cfg_nxt.lim_off[tbpc_pkg::SET_LOW] = lim_off_new;
        end
        tbpc_pkg::REG_MID_TIMES: begin
          cfg_nxt.lim_on[tbpc_pkg::SET_MID]  = lim_on_new;
          cfg_nxt.lim_off[tbpc_pkg::SET_MID] = lim_off_new;
        end
        tbpc_pkg::REG_HIGH_TIMES: begin
          cfg_nxt.lim_on[tbpc_pkg::SET_HIGH]  = lim_on_new;
          cfg_nxt.lim_off[tbpc_pkg::SET_HIGH] = lim_off_new;
        end
        tbpc_pkg::REG_NIGHT_TIMES: begin
          cfg_nxt.lim_on[tbpc_pkg::SET_NIGHT]  = lim_on_new;
          cfg_nxt.lim_off[tbpc_pkg::SET_NIGHT] = lim_off_new;
        end
        default: begin
          // unknown index: write dropped
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.continuous <= 1'b0;
      cfg_r.low_thr    <= tbpc_pkg::LOW_THR_RST;
      cfg_r.high_thr   <= tbpc_pkg::HIGH_THR_RST;
      cfg_r.lim_on     <= {tbpc_pkg::NUM_SETS{LIM_RST}};
      cfg_r.lim_off    <= {tbpc_pkg::NUM_SETS{LIM_RST}};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/tbpc_cycler.sv */
`timescale 1ns / 1ps

module tbpc_cycler #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic                                sample_valid,
  input  logic signed [tbpc_pkg::TEMP_W-1:0]  sample_temperature,
  input  logic                                night_active,
  input  tbpc_pkg::cfg_t                      cfg,
  output tbpc_pkg::res_t                      res_nxt
);

  localparam int CW    = tbpc_pkg::CNT_W;
  localparam int TOT_W = tbpc_pkg::TOTAL_W;
  localparam int SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);

  // state
  logic                               relay_r, relay_nxt;
  logic signed [tbpc_pkg::TEMP_W-1:0] temp_r, temp_nxt;
  logic [CW-1:0]                      phase_r, phase_nxt;
  logic [CW-1:0]                      run_ms_r, run_ms_nxt;
  logic [SUB_W-1:0]                   run_sub_r, run_sub_nxt;
  logic [CW-1:0]                      run_sec_r, run_sec_nxt;
  logic [TOT_W-1:0]                   total_r, total_nxt;

  tbpc_pkg::band_t                    band;
  logic [1:0]                         set_sel;
  logic [CW-1:0]                      phase_inc;
  logic [CW-1:0]                      run_ms_inc;
  logic [SUB_W-1:0]                   run_sub_inc;
  logic [CW-1:0]                      run_sec_inc;
  logic [tbpc_pkg::LIM_W-1:0]         limit;
  logic                               reached;
  logic                               change;
  logic [TOT_W:0]                     sum;
  logic [TOT_W-1:0]                   total_sat;

  // sample update comes first
  assign temp_nxt = sample_valid ? sample_temperature : temp_r;

  // band choice
  always_comb begin
    priority if (cfg.continuous) begin
      band = tbpc_pkg::BAND_CONT;
    end else if (night_active) begin
      band = tbpc_pkg::BAND_NIGHT;
    end else if (temp_nxt < cfg.low_thr) begin
      band = tbpc_pkg::BAND_LOW;
    end else if (temp_nxt < cfg.high_thr) begin
      band = tbpc_pkg::BAND_MID;
    end else begin
      band = tbpc_pkg::BAND_HIGH;
    end
  end

  always_comb begin
    unique case (band)
      tbpc_pkg::BAND_LOW:   set_sel = tbpc_pkg::SET_LOW;
      tbpc_pkg::BAND_MID:   set_sel = tbpc_pkg::SET_MID;
      tbpc_pkg::BAND_HIGH:  set_sel = tbpc_pkg::SET_HIGH;
      tbpc_pkg::BAND_NIGHT: set_sel = tbpc_pkg::SET_NIGHT;
      default:              set_sel = tbpc_pkg::SET_LOW;
    endcase
  end

  // saturating phase count
  assign phase_inc = (phase_r == tbpc_pkg::CNT_MAX) ? phase_r : phase_r + 1'b1;

  // run time kept as ticks plus seconds/sub-second split, so no divide needed
  always_comb begin
    run_ms_inc  = run_ms_r;
    run_sub_inc = run_sub_r;
    run_sec_inc = run_sec_r;
    if (relay_r && (run_ms_r != tbpc_pkg::CNT_MAX)) begin
      run_ms_inc = run_ms_r + 1'b1;
      if (run_sub_r == SUB_LAST) begin
        run_sub_inc = '0;
        run_sec_inc = run_sec_r + 1'b1;
      end else begin
        run_sub_inc = run_sub_r + 1'b1;
      end
    end
  end

  // on/off decision
  assign limit   = relay_r ? cfg.lim_on[set_sel] : cfg.lim_off[set_sel];
  assign reached = {1'b0, phase_inc} >= limit;

  always_comb begin
    priority if (cfg.continuous) begin
      relay_nxt = 1'b1;
    end else if (reached) begin
      relay_nxt = !relay_r;
    end else begin
      relay_nxt = relay_r;
    end
  end

  assign change = relay_nxt != relay_r;

  // saturating total, added in parallel with the decision
  assign sum       = {1'b0, total_r} + (TOT_W+1)'(run_sec_inc);
  assign total_sat = sum[TOT_W] ? '1 : sum[TOT_W-1:0];

  always_comb begin
    phase_nxt   = (change && !cfg.continuous) ? '0 : phase_inc;
    run_ms_nxt  = run_ms_inc;
    run_sub_nxt = run_sub_inc;
    run_sec_nxt = run_sec_inc;
    total_nxt   = total_r;
    if (change && relay_nxt) begin
      run_ms_nxt  = '0;
      run_sub_nxt = '0;
      run_sec_nxt = '0;
    end
    if (change && !relay_nxt) begin
      total_nxt = total_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r   <= 1'b0;
      temp_r    <= '0;
      phase_r   <= '0;
      run_ms_r  <= '0;
      run_sub_r <= '0;
      run_sec_r <= '0;
      total_r   <= '0;
    end else if (step) begin
      relay_r   <= relay_nxt;
      temp_r    <= temp_nxt;
      phase_r   <= phase_nxt;
      run_ms_r  <= run_ms_nxt;
      run_sub_r <= run_sub_nxt;
      run_sec_r <= run_sec_nxt;
      total_r   <= total_nxt;
    end
  end

  assign res_nxt.pump_on = relay_nxt;
  assign res_nxt.band    = band;
  assign res_nxt.total   = total_nxt;

endmodule

/* sv/temperature_banded_pump_cycler_core.sv */
// Temperature-banded pump cycler.
// Input channel (in_*): one transfer per timer tick, carrying an optional
// temperature sample (1/16 degree) and the night flag. Each accepted tick
// advances the cycle timers and yields exactly one result.
// Result channel (out_*): relay drive, band code and the saturating total of
// whole run seconds. The result of a tick is valid in the cycle after its
// transfer; a new tick is taken every cycle unless out_stall holds a
// waiting result, so throughput is one per cycle, set by the single
// registered pass from the state registers to the result register.
// When out_stall holds a waiting result, in_stall is raised in the same cycle
// and the result register holds its payload until it is taken.
// Configuration (cfg_*): cfg_ready is always high; cfg_index selects the
// register, on/off seconds are converted to tick limits as they are written.
// Reset (rst_n low, synchronous) restores the default configuration, turns
// the pump off, clears all timers and the total and empties the result
// register. No clearing pass is needed; ticks are accepted straight away.
`timescale 1ns / 1ps
`include "temperature_banded_pump_cycler_core_defines.svh"

module temperature_banded_pump_cycler_core #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input ticks
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_sample_valid,
  input  logic signed [tbpc_pkg::TEMP_W-1:0]  in_sample_temperature,
  input  logic                                in_night_active,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_pump_on,
  output logic [2:0]                          out_cycle_band,
  output logic [tbpc_pkg::TOTAL_W-1:0]        out_total_run_seconds,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tbpc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [tbpc_pkg::DATA_W-1:0]         cfg_wdata
);

  tbpc_pkg::cfg_t cfg_q;
  tbpc_pkg::res_t res_nxt;
  tbpc_pkg::res_t res_r;
  logic           out_valid_r, out_valid_nxt;
  logic           in_accept;

  assign cfg_ready = 1'b1;

  tbpc_cfg_regs #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cfg_valid && cfg_ready),
    .wr_idx (cfg_index),
    .wr_data(cfg_wdata),
    .cfg    (cfg_q)
  );

  // transfer control: stall only while a result waits to be taken
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  tbpc_cycler #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_cycler (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (in_accept),
    .sample_valid      (in_sample_valid),
    .sample_temperature(in_sample_temperature),
    .night_active      (in_night_active),
    .cfg               (cfg_q),
    .res_nxt           (res_nxt)
  );

  // result register
  assign out_valid_nxt = in_accept || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_pump_on           = res_r.pump_on;
  assign out_cycle_band        = res_r.band;
  assign out_total_run_seconds = res_r.total;

  // checks
  `TBPC_ASSERT_NEXT(a_cont_keeps_on, clk, rst_n, in_accept && cfg_q.continuous, out_pump_on && (out_cycle_band == tbpc_pkg::BAND_CONT), "continuous mode must report pump on in band 0")
  `TBPC_ASSERT_NEXT(a_total_no_drop, clk, rst_n, in_accept && out_valid_r, out_total_run_seconds >= $past(out_total_run_seconds), "run total went down")
  `TBPC_ASSERT_NEXT(a_total_on_stop, clk, rst_n, in_accept && out_valid_r, (out_total_run_seconds == $past(out_total_run_seconds)) || !out_pump_on, "run total changed without pump stop")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import tbpc_pkg::*;

  localparam int TICKS_PER_S  = 1000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int TIMEOUT_NS   = 5_000_000;

  // Index with no register behind it
  localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  logic                     in_valid;
  logic                     in_stall;
  logic                     in_sample_valid;
  logic signed [TEMP_W-1:0] in_sample_temperature;
  logic                     in_night_active;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_pump_on;
  logic [2:0]               out_cycle_band;
  logic [TOTAL_W-1:0]       out_total_run_seconds;

  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index;
  logic [DATA_W-1:0]        cfg_wdata;

  // Idle rates in percent, changed between phases
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;

  // Long receiver hold-off
  event hold_go;
  logic long_hold = 1'b0;

  int   bad_results = 0;
  res_t tick_results_due[$];

  // Predictor copy of the configuration (reset values)
  logic                     cont_mode   = 1'b0;
  logic signed [TEMP_W-1:0] thr_low     = LOW_THR_RST;
  logic signed [TEMP_W-1:0] thr_high    = HIGH_THR_RST;
  logic [DATA_W-1:0]        times_low   = {16'(TIME_RST_S), 16'(TIME_RST_S)};
  logic [DATA_W-1:0]        times_mid   = {16'(TIME_RST_S), 16'(TIME_RST_S)};
  logic [DATA_W-1:0]        times_high  = {16'(TIME_RST_S), 16'(TIME_RST_S)};
  logic [DATA_W-1:0]        times_night = {16'(TIME_RST_S), 16'(TIME_RST_S)};

  // Predictor copy of the pump state
  logic                     relay     = 1'b0;
  logic signed [TEMP_W-1:0] held_temp = '0;
  logic [CNT_W-1:0]         phase_ms  = '0;
  logic [CNT_W-1:0]         run_ms    = '0;
  logic [TOTAL_W-1:0]       run_total = '0;

  temperature_banded_pump_cycler_core #(
    .TICKS_PER_SECOND(TICKS_PER_S)
  ) dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_sample_valid       (in_sample_valid),
    .in_sample_temperature (in_sample_temperature),
    .in_night_active       (in_night_active),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_pump_on           (out_pump_on),
    .out_cycle_band        (out_cycle_band),
    .out_total_run_seconds (out_total_run_seconds),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One millisecond tick: sample update, band choice, timers, relay decision
  function void advance_pump_cycler(input logic sample_ok,
                                    input logic signed [TEMP_W-1:0] sample,
                                    input logic night);
    res_t              r;
    band_t             band;
    logic [DATA_W-1:0] times;
    logic [31:0]       limit;
    logic [31:0]       secs;
    logic [32:0]       sum;
    logic              next_relay;
    if (sample_ok) held_temp = sample;
    if (cont_mode) begin
      band  = BAND_CONT;
      times = '0;
    end else if (night) begin
      band  = BAND_NIGHT;
      times = times_night;
    end else if (held_temp < thr_low) begin
      band  = BAND_LOW;
      times = times_low;
    end else if (held_temp < thr_high) begin
      band  = BAND_MID;
      times = times_mid;
    end else begin
      band  = BAND_HIGH;
      times = times_high;
    end
    // both counters stick at their ceiling
    if (phase_ms != CNT_MAX) phase_ms = phase_ms + 1'b1;
    if (relay && run_ms != CNT_MAX) run_ms = run_ms + 1'b1;
    next_relay = relay;
    if (cont_mode) begin
      next_relay = 1'b1;
    end else if (relay) begin
      limit = {16'd0, times[15:0]} * 32'(TICKS_PER_S);
      if ({6'd0, phase_ms} >= limit) next_relay = 1'b0;
    end else begin
      limit = {16'd0, times[31:16]} * 32'(TICKS_PER_S);
      if ({6'd0, phase_ms} >= limit) next_relay = 1'b1;
    end
    if (next_relay != relay) begin
      if (next_relay) begin
        run_ms = '0;
      end else begin
        secs      = {6'd0, run_ms} / 32'(TICKS_PER_S);
        sum       = {1'b0, run_total} + {1'b0, secs};
        run_total = sum[32] ? '1 : sum[31:0];
      end
      // a change forced by continuous mode keeps the phase timer running
      if (!cont_mode) phase_ms = '0;
      relay = next_relay;
    end
    r.pump_on = relay;
    r.band    = band;
    r.total   = run_total;
    tick_results_due.push_back(r);
  endfunction

  // One tick transfer, then an optional random gap
  task automatic send_tick(input logic sample_ok, input logic signed [TEMP_W-1:0] sample,
                           input logic night);
    in_valid              <= 1'b1;
    in_sample_valid       <= sample_ok;
    in_sample_temperature <= sample;
    in_night_active       <= night;
    do @(posedge clk); while (in_stall !== 1'b0);
    advance_pump_cycler(sample_ok, sample, night);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // Temperatures sit on a threshold now and then so both sides of it are seen
  function automatic logic signed [TEMP_W-1:0] pick_temperature();
    int v;
    case ($urandom_range(9))
      0: return thr_low;
      1: return thr_high;
      default: begin
        v = $urandom_range(2880) - 880;
        return v[TEMP_W-1:0];
      end
    endcase
  endfunction

  task automatic send_random_tick();
    logic                     sample_ok;
    logic signed [TEMP_W-1:0] sample;
    logic                     night;
    sample_ok = ($urandom_range(99) < 40);
    sample    = pick_temperature();
    night     = ($urandom_range(99) < 25);
    send_tick(sample_ok, sample, night);
  endtask

  // Register write; the caller lowers cfg_valid after the last one
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_CONTINUOUS:  cont_mode   = data[0];
      REG_LOW_THR:     thr_low     = data[TEMP_W-1:0];
      REG_HIGH_THR:    thr_high    = data[TEMP_W-1:0];
      REG_LOW_TIMES:   times_low   = data;
      REG_MID_TIMES:   times_mid   = data;
      REG_HIGH_TIMES:  times_high  = data;
      REG_NIGHT_TIMES: times_night = data;
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] sext_temp(input int t);
    logic [TEMP_W-1:0] v;
    v = t[TEMP_W-1:0];
    return {{(DATA_W-TEMP_W){v[TEMP_W-1]}}, v};
  endfunction

  // Stop offering ticks and let every outstanding result come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tick_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly short on/off times so the relay actually cycles; sometimes very
  // long limits that still lie below the saturated timer's ceiling
  function automatic logic [DATA_W-1:0] pick_times();
    logic [15:0] on_s;
    logic [15:0] off_s;
    int          pick;
    pick  = $urandom_range(19);
    on_s  = 16'($urandom_range(1));
    off_s = 16'($urandom_range(1));
    if (pick == 0) return $urandom();
    if (pick == 1) on_s = 16'hFFFF;
    if (pick == 2) off_s = 16'hFFFF;
    if (pick == 3) on_s = 16'd2;
    return {off_s, on_s};
  endfunction

  task automatic load_random_setup();
    write_reg(REG_CONTINUOUS, DATA_W'($urandom_range(99) < 20));
    write_reg(REG_LOW_THR, sext_temp($urandom_range(2880) - 880));
    write_reg(REG_HIGH_THR, sext_temp($urandom_range(2880) - 880));
    write_reg(REG_LOW_TIMES, pick_times());
    write_reg(REG_MID_TIMES, pick_times());
    write_reg(REG_HIGH_TIMES, pick_times());
    write_reg(REG_NIGHT_TIMES, pick_times());
    if ($urandom_range(9) == 0) write_reg(REG_NONE, $urandom());
    cfg_valid <= 1'b0;
  endtask

  // Reset configuration: every band boundary and both temperature extremes
  task automatic check_band_edges();
    send_tick(1'b1, -12'sd880, 1'b0);
    send_tick(1'b1, 12'sd2000, 1'b0);
    send_tick(1'b0, 12'sd0, 1'b1);
    send_tick(1'b1, 12'sd319, 1'b0);
    send_tick(1'b1, 12'sd320, 1'b0);
    send_tick(1'b1, 12'sd399, 1'b0);
    send_tick(1'b1, 12'sd400, 1'b0);
    drain_results();
  endtask

  // Zero on and off times flip the relay on every tick
  task automatic check_zero_times();
    write_reg(REG_LOW_TIMES, '0);
    write_reg(REG_MID_TIMES, '0);
    write_reg(REG_HIGH_TIMES, '0);
    write_reg(REG_NIGHT_TIMES, '0);
    cfg_valid <= 1'b0;
    send_tick(1'b1, 12'sd100, 1'b0);
    send_tick(1'b0, 12'sd0, 1'b1);
    send_tick(1'b1, 12'sd350, 1'b0);
    send_tick(1'b1, 12'sd1500, 1'b0);
    drain_results();
  endtask

  // Low threshold above high threshold, both at the range ends
  task automatic check_crossed_thresholds();
    write_reg(REG_LOW_THR, sext_temp(2000));
    write_reg(REG_HIGH_THR, sext_temp(-880));
    cfg_valid <= 1'b0;
    send_tick(1'b1, 12'sd1999, 1'b0);
    send_tick(1'b1, 12'sd2000, 1'b0);
    drain_results();
    write_reg(REG_LOW_THR, sext_temp(-880));
    write_reg(REG_HIGH_THR, sext_temp(2000));
    cfg_valid <= 1'b0;
    send_tick(1'b1, -12'sd880, 1'b0);
    send_tick(1'b1, 12'sd1999, 1'b0);
    send_tick(1'b1, 12'sd2000, 1'b0);
    drain_results();
  endtask

  // Continuous mode beats night; leaving it with the on time used up
  // switches the pump off straight away
  task automatic check_continuous_night();
    write_reg(REG_CONTINUOUS, 32'd1);
    cfg_valid <= 1'b0;
    send_tick(1'b0, 12'sd0, 1'b1);
    send_tick(1'b1, 12'sd500, 1'b0);
    drain_results();
    write_reg(REG_CONTINUOUS, 32'd0);
    cfg_valid <= 1'b0;
    send_tick(1'b0, 12'sd0, 1'b0);
    drain_results();
  endtask

  task automatic check_unknown_index();
    write_reg(REG_NONE, '1);
    cfg_valid <= 1'b0;
    send_tick(1'b0, 12'sd0, 1'b1);
    drain_results();
  endtask

  // Random setups, each held for a random run of ticks
  task automatic run_random_ticks(input int count);
    int left;
    int len;
    left = count;
    while (left > 0) begin
      load_random_setup();
      len = $urandom_range(250, 80);
      if (len > left) len = left;
      repeat (len) send_random_tick();
      left -= len;
      drain_results();
    end
  endtask

  // Receiver holds off while ticks keep coming, so the input side must stall
  task automatic check_input_backpressure(input int count);
    -> hold_go;
    repeat (count) send_random_tick();
    drain_results();
  endtask

  // Long hold-off, counted here
  always begin
    @(hold_go);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Result side stall
  always @(posedge clk) begin
    out_stall <= long_hold || ($urandom_range(99) < receiver_idle_pct);
  end

  // Every result transfer against the oldest outstanding prediction
  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (tick_results_due.size() == 0) begin
        $error("result transfer with no tick outstanding");
        bad_results++;
      end else begin
        want = tick_results_due.pop_front();
        if (out_pump_on !== want.pump_on) begin
          $error("pump_on: expected %0d, got %0d", want.pump_on, out_pump_on);
          bad_results++;
        end
        if (out_cycle_band !== want.band) begin
          $error("cycle_band: expected %0d, got %0d", want.band, out_cycle_band);
          bad_results++;
        end
        if (out_total_run_seconds !== want.total) begin
          $error("total_run_seconds: expected %0d, got %0d", want.total,
                 out_total_run_seconds);
          bad_results++;
        end
      end
    end
  end

  initial begin
    rst_n                 <= 1'b0;
    in_valid              <= 1'b0;
    in_sample_valid       <= 1'b0;
    in_sample_temperature <= '0;
    in_night_active       <= 1'b0;
    cfg_valid             <= 1'b0;
    cfg_index             <= '0;
    cfg_wdata             <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct   = 31;
    receiver_idle_pct = 83;
    check_band_edges();
    check_zero_times();
    check_crossed_thresholds();
    check_continuous_night();
    check_unknown_index();
    run_random_ticks(600);

    sender_idle_pct   = 83;
    receiver_idle_pct = 31;
    run_random_ticks(600);

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    check_input_backpressure(150);
    run_random_ticks(400);

    if (bad_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
